FILE: design/pfdm_pkg.sv
// ----------------------------------------------------------------------------
// pfdm_pkg
// Shared widths, constants and the period record of the pulse meter.
// ----------------------------------------------------------------------------
package pfdm_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int TOT_W       = COUNT_WIDTH + 1;
  localparam int CLK_W       = 30;
  localparam int FREQ_W      = 29;
  localparam int DUTY_W      = 7;
  localparam int SCALE_W     = 7;
  localparam int MUL_W       = COUNT_WIDTH + SCALE_W;
  localparam int NUM_W       = (CLK_W > MUL_W) ? CLK_W : MUL_W;
  localparam int STEP_W      = $clog2(NUM_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SCALE_W-1:0]     DUTY_SCALE     = SCALE_W'(100);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = {COUNT_WIDTH{1'b1}};
  localparam logic [CLK_W-1:0]       CLOCK_HZ_RESET = CLK_W'(8000000);

  // one closed period, handed from the counter to the divider
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] high_ticks;
    logic [COUNT_WIDTH-1:0] low_ticks;
    logic                   overflowed;
  } meas_t;

  // queue status seen by the counter
  typedef struct packed {
    logic full;
  } q_stat_t;

  // queue head seen by the divider
  typedef struct packed {
    logic  valid;
    meas_t data;
  } q_head_t;

endpackage

FILE: design/pfdm_in_if.sv
// ----------------------------------------------------------------------------
// pfdm_in_if
// Sample channel: one sampled level per word.
// ----------------------------------------------------------------------------
interface pfdm_in_if;
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

FILE: design/pfdm_out_if.sv
// ----------------------------------------------------------------------------
// pfdm_out_if
// Result channel: frequency, duty cycle and saturation flag per period.
// ----------------------------------------------------------------------------
interface pfdm_out_if;
  logic        valid;
  logic        ready;
  logic [28:0] frequency_hz;
  logic [6:0]  duty_percent;
  logic        saturated;

  modport source (output valid, output frequency_hz, output duty_percent,
                  output saturated, input ready);
  modport sink   (input valid, input frequency_hz, input duty_percent,
                  input saturated, output ready);
endinterface

FILE: design/pfdm_front.sv
// ----------------------------------------------------------------------------
// pfdm_front
// Edge detector and saturating high/low tick counters; closes a period on
// each rising edge after a low phase and pushes it to the queue.
// ----------------------------------------------------------------------------
module pfdm_front (
  input  logic             clk,
  input  logic             rst_n,
  pfdm_in_if.sink          in_ch,
  input  pfdm_pkg::q_stat_t q_stat,
  output logic             push,
  output pfdm_pkg::meas_t  push_data
);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_HIGH,
    PH_LOW
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic                             last_level_r, last_level_nxt;
  logic [pfdm_pkg::COUNT_WIDTH-1:0] high_r, high_nxt;
  logic [pfdm_pkg::COUNT_WIDTH-1:0] low_r, low_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             accept;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign push_data.high_ticks = high_r;
  assign push_data.low_ticks  = low_r;
  assign push_data.overflowed = ovf_r;

  always_comb begin
    phase_nxt      = phase_r;
    last_level_nxt = last_level_r;
    high_nxt       = high_r;
    low_nxt        = low_r;
    ovf_nxt        = ovf_r;
    push           = 1'b0;
    if (accept) begin
      last_level_nxt = in_ch.level;
      case (phase_r)
        PH_HIGH: begin
          if (in_ch.level) begin
            if (high_r == pfdm_pkg::COUNT_MAX) begin
              ovf_nxt = 1'b1;
            end else begin
              high_nxt = high_r + 1'b1;
            end
          end else begin
            low_nxt   = pfdm_pkg::COUNT_WIDTH'(1);
            phase_nxt = PH_LOW;
          end
        end
        PH_LOW: begin
          if (!in_ch.level) begin
            if (low_r == pfdm_pkg::COUNT_MAX) begin
              ovf_nxt = 1'b1;
            end else begin
              low_nxt = low_r + 1'b1;
            end
          end else begin
            // period closes; the rising tick is the first high tick of the next
            push      = 1'b1;
            phase_nxt = PH_HIGH;
            high_nxt  = pfdm_pkg::COUNT_WIDTH'(1);
            low_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
        default: begin
          if (in_ch.level && !last_level_r) begin
            phase_nxt = PH_HIGH;
            high_nxt  = pfdm_pkg::COUNT_WIDTH'(1);
            low_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else begin
            phase_nxt = PH_WAIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      last_level_r <= 1'b0;
      high_r       <= '0;
      low_r        <= '0;
      ovf_r        <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      last_level_r <= last_level_nxt;
      high_r       <= high_nxt;
      low_r        <= low_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

FILE: design/pfdm_queue.sv
// ----------------------------------------------------------------------------
// pfdm_queue
// Short FIFO of closed periods between the counter and the divider.
// ----------------------------------------------------------------------------
module pfdm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pfdm_pkg::meas_t   push_data,
  input  logic              pop,
  output pfdm_pkg::q_stat_t q_stat,
  output pfdm_pkg::q_head_t q_head
);

  pfdm_pkg::meas_t                  mem_r [pfdm_pkg::QUEUE_DEPTH];
  logic [pfdm_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [pfdm_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [pfdm_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             do_push, do_pop;

  assign q_stat.full  = (count_r == pfdm_pkg::QCNT_W'(pfdm_pkg::QUEUE_DEPTH));
  assign q_head.valid = (count_r != '0);
  assign q_head.data  = mem_r[rd_ptr_r];

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && q_head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == pfdm_pkg::QPTR_W'(pfdm_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == pfdm_pkg::QPTR_W'(pfdm_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/pfdm_back.sv
// ----------------------------------------------------------------------------
// pfdm_back
// Bit-serial restoring divider: frequency and duty quotients share one loop,
// one quotient bit of each per cycle, then a result register on the output.
// ----------------------------------------------------------------------------
module pfdm_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [pfdm_pkg::CLK_W-1:0] clock_hz,
  input  pfdm_pkg::q_head_t          q_head,
  output logic                       pop,
  pfdm_out_if.source                 out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  localparam int NUM_W = pfdm_pkg::NUM_W;
  localparam int TOT_W = pfdm_pkg::TOT_W;

  state_t                       state_r, state_nxt;
  logic [pfdm_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [NUM_W-1:0]             num_f_r, num_f_nxt;
  logic [NUM_W-1:0]             num_d_r, num_d_nxt;
  logic [TOT_W-1:0]             rem_f_r, rem_f_nxt;
  logic [TOT_W-1:0]             rem_d_r, rem_d_nxt;
  logic [TOT_W-1:0]             div_r, div_nxt;
  logic                         sat_r, sat_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [pfdm_pkg::FREQ_W-1:0]  out_freq_r, out_freq_nxt;
  logic [pfdm_pkg::DUTY_W-1:0]  out_duty_r, out_duty_nxt;
  logic                         out_sat_r, out_sat_nxt;

  logic [pfdm_pkg::MUL_W-1:0]   prod;
  logic [TOT_W:0]               sh_f, sh_d;
  logic                         ge_f, ge_d;
  logic                         out_free;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frequency_hz = out_freq_r;
  assign out_ch.duty_percent = out_duty_r;
  assign out_ch.saturated    = out_sat_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = (state_r == ST_IDLE) && q_head.valid;

  assign prod = pfdm_pkg::MUL_W'(q_head.data.high_ticks) *
                pfdm_pkg::MUL_W'(pfdm_pkg::DUTY_SCALE);

  // restoring step: partial remainder always stays below the divisor
  assign sh_f = {rem_f_r, num_f_r[NUM_W-1]};
  assign sh_d = {rem_d_r, num_d_r[NUM_W-1]};
  assign ge_f = (sh_f >= {1'b0, div_r});
  assign ge_d = (sh_d >= {1'b0, div_r});

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    num_f_nxt     = num_f_r;
    num_d_nxt     = num_d_r;
    rem_f_nxt     = rem_f_r;
    rem_d_nxt     = rem_d_r;
    div_nxt       = div_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_freq_nxt  = out_freq_r;
    out_duty_nxt  = out_duty_r;
    out_sat_nxt   = out_sat_r;
    case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          num_f_nxt = NUM_W'(clock_hz);
          num_d_nxt = NUM_W'(prod);
          rem_f_nxt = '0;
          rem_d_nxt = '0;
          div_nxt   = TOT_W'(q_head.data.high_ticks) + TOT_W'(q_head.data.low_ticks);
          sat_nxt   = q_head.data.overflowed;
          step_nxt  = pfdm_pkg::STEP_W'(NUM_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_f_nxt = ge_f ? TOT_W'(sh_f - {1'b0, div_r}) : sh_f[TOT_W-1:0];
        rem_d_nxt = ge_d ? TOT_W'(sh_d - {1'b0, div_r}) : sh_d[TOT_W-1:0];
        num_f_nxt = {num_f_r[NUM_W-2:0], ge_f};
        num_d_nxt = {num_d_r[NUM_W-2:0], ge_d};
        step_nxt  = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_freq_nxt  = num_f_r[pfdm_pkg::FREQ_W-1:0];
          out_duty_nxt  = num_d_r[pfdm_pkg::DUTY_W-1:0];
          out_sat_nxt   = sat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    num_f_r    <= num_f_nxt;
    num_d_r    <= num_d_nxt;
    rem_f_r    <= rem_f_nxt;
    rem_d_r    <= rem_d_nxt;
    div_r      <= div_nxt;
    sat_r      <= sat_nxt;
    out_freq_r <= out_freq_nxt;
    out_duty_r <= out_duty_nxt;
    out_sat_r  <= out_sat_nxt;
  end

endmodule

FILE: design/pulse_frequency_duty_meter.sv
// ----------------------------------------------------------------------------
// pulse_frequency_duty_meter
// Measures period, frequency and duty cycle of a sampled digital wave.
//
//   channel   dir  word                                       handshake
//   in_ch     in   level                                      valid/ready
//   out_ch    out  frequency_hz, duty_percent, saturated      valid/ready
//   cfg_*     in   clock_hz (cfg_wdata)                       cfg_we, no wait
//
// The counter takes one sample per cycle; in_ch.ready drops only while the
// two-entry period queue is full.
// Each closed period passes the divider as a load, 31 bit-serial steps and an
// output load; this loop sets the sustained result rate.
// Synchronous active-low reset; clock_hz resets to 8000000.
// A stalled result holds in the output register while the divider works on
// the next queued period.
// ----------------------------------------------------------------------------
module pulse_frequency_duty_meter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pfdm_pkg::CLK_W-1:0] cfg_wdata,
  pfdm_in_if.sink                    in_ch,
  pfdm_out_if.source                 out_ch
);

  logic [pfdm_pkg::CLK_W-1:0] clock_hz_r, clock_hz_nxt;
  pfdm_pkg::q_stat_t          q_stat;
  pfdm_pkg::q_head_t          q_head;
  pfdm_pkg::meas_t            push_data;
  logic                       push;
  logic                       pop;

  assign clock_hz_nxt = cfg_we ? cfg_wdata : clock_hz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= pfdm_pkg::CLOCK_HZ_RESET;
    end else begin
      clock_hz_r <= clock_hz_nxt;
    end
  end

  pfdm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  pfdm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_stat    (q_stat),
    .q_head    (q_head)
  );

  pfdm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clock_hz (clock_hz_r),
    .q_head   (q_head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // a period word must never be dropped at a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("period pushed into full queue");

  // every queued period spans at least one high and one low tick
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_head.data.high_ticks != '0 && q_head.data.low_ticks != '0))
    else $error("queued period with empty phase");

  // high ticks never exceed the period, so duty stays within range
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.duty_percent < 7'd100))
    else $error("duty out of range");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pulse frequency and duty cycle meter. A queue
// of sampled levels, built as runs of high and low ticks, feeds a driver; each
// accepted level steps a cycle-free copy of the meter, and every closed period
// it predicts is checked against the result words. Phases vary the clock_hz
// setting and the idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_TICKS = 64;
  localparam int HOLD_TICKS   = 400;
  localparam int REPORT_MAX   = 10;

  typedef enum logic [1:0] {
    SEEK_RISE    = 2'd0,
    MEASURE_HIGH = 2'd1,
    MEASURE_LOW  = 2'd2
  } meter_phase_t;

  typedef struct packed {
    logic [pfdm_pkg::FREQ_W-1:0] freq;
    logic [pfdm_pkg::DUTY_W-1:0] duty;
    logic                        sat;
  } period_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [pfdm_pkg::CLK_W-1:0] cfg_wdata;

  pfdm_in_if  in_ch ();
  pfdm_out_if out_ch ();

  pulse_frequency_duty_meter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // meter copy
  logic                             prev_level;
  meter_phase_t                     meter_phase;
  logic [pfdm_pkg::COUNT_WIDTH-1:0] high_count;
  logic [pfdm_pkg::COUNT_WIDTH-1:0] low_count;
  logic                             count_sat;
  logic [pfdm_pkg::CLK_W-1:0]       sample_hz;

  logic           pending_levels[$];
  period_result_t expected_periods[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_req;
  int  hold_left;
  int  mismatches;
  int  quiet_cycles;
  logic wave_level;

  function void open_period();
    meter_phase = MEASURE_HIGH;
    high_count  = pfdm_pkg::COUNT_WIDTH'(1);
    low_count   = '0;
    count_sat   = 1'b0;
  endfunction

  function void take_level(logic lvl);
    logic                       rising;
    logic [pfdm_pkg::TOT_W-1:0] total;
    period_result_t             res;
    rising     = lvl && !prev_level;
    prev_level = lvl;
    case (meter_phase)
      MEASURE_HIGH: begin
        if (lvl) begin
          if (high_count == pfdm_pkg::COUNT_MAX) count_sat = 1'b1;
          else high_count = high_count + 1'b1;
        end else begin
          low_count   = pfdm_pkg::COUNT_WIDTH'(1);
          meter_phase = MEASURE_LOW;
        end
      end
      MEASURE_LOW: begin
        if (!lvl) begin
          if (low_count == pfdm_pkg::COUNT_MAX) count_sat = 1'b1;
          else low_count = low_count + 1'b1;
        end else begin
          // rising edge closes the period and opens the next one
          total = pfdm_pkg::TOT_W'(high_count) + pfdm_pkg::TOT_W'(low_count);
          res   = '0;
          if (total != '0) begin
            res.freq = pfdm_pkg::FREQ_W'(64'(sample_hz) / 64'(total));
            res.duty = pfdm_pkg::DUTY_W'(
                         (64'(high_count) * 64'(pfdm_pkg::DUTY_SCALE)) / 64'(total));
          end
          res.sat = count_sat;
          expected_periods.push_back(res);
          open_period();
        end
      end
      default: begin
        if (rising) open_period();
        else meter_phase = SEEK_RISE;
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.level <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) take_level(in_ch.level);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_levels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.level <= pending_levels.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with a long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_TICKS;
      hold_req  = 1'b0;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    period_result_t got;
    period_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.freq = out_ch.frequency_hz;
      got.duty = out_ch.duty_percent;
      got.sat  = out_ch.saturated;
      if (expected_periods.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= REPORT_MAX)
          $display("unexpected word: freq=%0d duty=%0d sat=%0d",
                   got.freq, got.duty, got.sat);
      end else begin
        want = expected_periods.pop_front();
        if (got.freq !== want.freq || got.duty !== want.duty || got.sat !== want.sat) begin
          mismatches = mismatches + 1;
          if (mismatches <= REPORT_MAX)
            $display({"word mismatch: freq exp %0d got %0d, duty exp %0d got %0d,",
                      " sat exp %0d got %0d"},
                     want.freq, got.freq, want.duty, got.duty, want.sat, got.sat);
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_run(logic lvl, int len);
    repeat (len) pending_levels.push_back(lvl);
  endtask

  task automatic write_clock_hz(logic [pfdm_pkg::CLK_W-1:0] hz);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    sample_hz  = hz;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_levels.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_periods.size() != 0) @(posedge clk);
    // the divider may still be busy on nothing, let it settle
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic run_random(int send_pct, int stall_pct, int n_levels, bit long_hold);
    int count;
    int pick;
    int len;
    count          = 0;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    while (count < n_levels) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)      len = $urandom_range(1, 4);
      else if (pick < 95) len = $urandom_range(5, 40);
      else                len = $urandom_range(41, 200);
      add_run(wave_level, len);
      wave_level = !wave_level;
      count      = count + len;
    end
    if (long_hold) hold_req = 1'b1;
    drain_all();
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.level    = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    mismatches     = 0;
    quiet_cycles   = 0;
    hold_left      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wave_level     = 1'b0;
    prev_level     = 1'b0;
    meter_phase    = SEEK_RISE;
    high_count     = '0;
    low_count      = '0;
    count_sat      = 1'b0;
    sample_hz      = pfdm_pkg::CLOCK_HZ_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // high on the very first tick counts as a rising edge
    write_clock_hz(pfdm_pkg::CLK_W'(1000000000));
    add_run(1'b1, 1); add_run(1'b0, 1); add_run(1'b1, 1);
    add_run(1'b0, 3); add_run(1'b1, 4); add_run(1'b0, 1);
    add_run(1'b1, 1); add_run(1'b0, 1); add_run(1'b1, 1);
    drain_all();

    // smallest dividends: frequency truncates to zero
    write_clock_hz(pfdm_pkg::CLK_W'(1));
    add_run(1'b0, 2); add_run(1'b1, 1);
    drain_all();
    write_clock_hz('0);
    add_run(1'b1, 1); add_run(1'b0, 1); add_run(1'b1, 1);
    drain_all();

    // receiver holds off while the sender keeps offering
    write_clock_hz(pfdm_pkg::CLOCK_HZ_RESET);
    wave_level = 1'b0;
    run_random(0, 0, 110, 1'b1);

    write_clock_hz(pfdm_pkg::CLK_W'(1000000000));
    run_random(51, 0, 110, 1'b0);

    write_clock_hz(pfdm_pkg::CLK_W'($urandom_range(1, 1000000000)));
    run_random(0, 51, 110, 1'b0);

    write_clock_hz(pfdm_pkg::CLK_W'($urandom_range(1, 1000000000)));
    run_random(23, 23, 110, 1'b0);

    // a few wide periods at both duty extremes
    write_clock_hz(pfdm_pkg::CLK_W'($urandom_range(1, 1000000000)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_run(1'b0, 3);  add_run(1'b1, 63); add_run(1'b0, 1);
    add_run(1'b1, 1);  add_run(1'b0, 63); add_run(1'b1, 30);
    add_run(1'b0, 60); add_run(1'b1, 1);
    drain_all();

    if (mismatches == 0 && expected_periods.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
